// ----- sv/b64lw_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64lw_pkg - shared types and constants of the base64 line-wrap encoder
// Character codes, state encodings, the per-byte character set and the
// sextet-to-ASCII alphabet mapping.
// ============================================================================
package b64lw_pkg;

  // Default width of the running line counter
  localparam int unsigned LINE_COUNT_BITS_DEF = 10;

  // Line length register
  localparam int unsigned LEN_W     = 10;
  localparam logic [LEN_W-1:0] LEN_RESET = 10'd72;

  // Fixed character codes
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Position of the next byte in its three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  // Line break sequencer state
  typedef enum logic [1:0] {
    BRK_NONE = 2'd0,
    BRK_CR   = 2'd1,
    BRK_LF   = 2'd2
  } brk_e;

  // Up to four characters produced by one source byte
  typedef struct packed {
    logic [3:0][7:0] chars;     // characters in output order
    logic [3:0]      counted;   // character takes part in line counting
    logic [1:0]      last_idx;  // index of the final character
    logic            msg_end;   // byte closed the message
  } set_t;

  // Map a 6-bit value to its base64 ASCII character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ext;
    ext = {2'b00, v};
    if (v < 6'd26)      return 8'h41 + ext;
    else if (v < 6'd52) return 8'h61 + ext - 8'd26;
    else if (v < 6'd62) return 8'h30 + ext - 8'd52;
    else if (v == 6'd62) return 8'h2B;
    else                return 8'h2F;
  endfunction

endpackage

// ----- sv/b64lw_group.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64lw_group - byte grouping stage
// Accepts source bytes, tracks the three-byte group position and leftover
// bits, and registers the characters each byte completes, pad included.
// ============================================================================
module b64lw_group (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Source byte stream
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [7:0]      s_byte_i,
  input  logic            s_last_i,
  // Character set toward the emitter
  output logic            set_valid_o,
  input  logic            set_ready_i,
  output b64lw_pkg::set_t set_o
);
  import b64lw_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic       set_valid_q;
  set_t       set_q, set_d;
  logic       s_acc;

  assign s_ready_o = !set_valid_q || set_ready_i;
  assign s_acc     = s_valid_i && s_ready_o;

  // Build the character set for the incoming byte
  always_comb begin
    set_d         = '0;
    set_d.msg_end = s_last_i;
    phase_d       = phase_q;
    carry_d       = carry_q;
    case (phase_q)
      PH_SECOND: begin
        set_d.chars[0]   = b64_char({carry_q[1:0], s_byte_i[7:4]});
        set_d.counted[0] = 1'b1;
        carry_d          = s_byte_i[3:0];
        phase_d          = PH_THIRD;
        if (s_last_i) begin
          set_d.chars[1]   = b64_char({s_byte_i[3:0], 2'b00});
          set_d.counted[1] = 1'b1;
          set_d.chars[2]   = CHAR_PAD;
          set_d.last_idx   = 2'd2;
        end
      end
      PH_THIRD: begin
        set_d.chars[0]   = b64_char({carry_q, s_byte_i[7:6]});
        set_d.chars[1]   = b64_char(s_byte_i[5:0]);
        set_d.counted    = 4'b0011;
        set_d.last_idx   = 2'd1;
        carry_d          = 4'd0;
        phase_d          = PH_FIRST;
      end
      default: begin
        set_d.chars[0]   = b64_char(s_byte_i[7:2]);
        set_d.counted[0] = 1'b1;
        carry_d          = {2'b00, s_byte_i[1:0]};
        phase_d          = PH_SECOND;
        if (s_last_i) begin
          set_d.chars[1] = b64_char({s_byte_i[1:0], 4'b0000});
          set_d.chars[2] = CHAR_PAD;
          set_d.chars[3] = CHAR_PAD;
          set_d.counted  = 4'b0111;
          set_d.last_idx = 2'd3;
        end
      end
    endcase
    // Start a fresh group after the final byte
    if (s_last_i) begin
      phase_d = PH_FIRST;
      carry_d = 4'd0;
    end
  end

  // Advance group state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      carry_q     <= 4'd0;
      set_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        phase_q     <= phase_d;
        carry_q     <= carry_d;
        set_valid_q <= 1'b1;
      end else if (set_ready_i) begin
        set_valid_q <= 1'b0;
      end
    end
  end

  // Hold the set until the emitter takes it
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      set_q <= set_d;
    end
  end

  assign set_valid_o = set_valid_q;
  assign set_o       = set_q;

endmodule

// ----- sv/b64lw_emit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b64lw_emit - character emitter with line wrapping
// Sends the characters of one set one per cycle through the output register
// while it is not stalled, counts them and inserts CR LF when a line fills up.
// ============================================================================
module b64lw_emit #(
  parameter int unsigned LINE_COUNT_BITS = b64lw_pkg::LINE_COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [b64lw_pkg::LEN_W-1:0] line_length_i,
  // Character set from the grouping stage
  input  logic                        set_valid_i,
  output logic                        set_ready_o,
  input  b64lw_pkg::set_t             set_i,
  // Output character stream
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [7:0]                  m_char_o,
  output logic                        m_last_o
);
  import b64lw_pkg::*;

  localparam int unsigned CMP_W = (LINE_COUNT_BITS > LEN_W) ? LINE_COUNT_BITS : LEN_W;

  set_t                       set_q;
  logic                       busy_q, busy_d;
  logic [1:0]                 idx_q, idx_d;
  brk_e                       brk_q, brk_d;
  logic [LINE_COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_char_q, out_char_d;
  logic                       out_last_q, out_last_d;

  logic adv, emit_char, hit, is_final, done_now, load;

  // Output register free to take a new character
  assign adv       = !out_valid_q || m_ready_i;
  assign emit_char = adv && busy_q && (brk_q == BRK_NONE);
  assign is_final  = (idx_q == set_q.last_idx);
  assign cnt_inc   = cnt_q + 1'b1;
  assign hit       = emit_char && set_q.counted[idx_q] && (line_length_i != '0) &&
                     (CMP_W'(cnt_inc) == CMP_W'(line_length_i));
  assign done_now  = adv && busy_q &&
                     (((brk_q == BRK_NONE) && is_final && !hit) ||
                      ((brk_q == BRK_LF) && is_final));
  assign set_ready_o = !busy_q || done_now;
  assign load        = set_valid_i && set_ready_o;

  // Next state of the sequencer and line counter
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    brk_d  = brk_q;
    cnt_d  = cnt_q;
    if (adv && busy_q) begin
      case (brk_q)
        BRK_CR: begin
          brk_d = BRK_LF;
        end
        BRK_LF: begin
          brk_d = BRK_NONE;
          if (!is_final) idx_d = idx_q + 2'd1;
        end
        default: begin
          if (set_q.counted[idx_q] && (line_length_i != '0)) begin
            cnt_d = hit ? '0 : cnt_inc;
          end
          if (hit) begin
            brk_d = BRK_CR;
          end else if (!is_final) begin
            idx_d = idx_q + 2'd1;
          end
        end
      endcase
    end
    if (done_now) begin
      busy_d = 1'b0;
      if (set_q.msg_end) cnt_d = '0;
    end
    if (load) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
      brk_d  = BRK_NONE;
    end
  end

  // Next output word
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = busy_q;
      out_last_d  = done_now;
      case (brk_q)
        BRK_CR:  out_char_d = CHAR_CR;
        BRK_LF:  out_char_d = CHAR_LF;
        default: out_char_d = set_q.chars[idx_q];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      brk_q       <= BRK_NONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      brk_q       <= brk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (load) set_q <= set_i;
  end

  assign m_valid_o = out_valid_q;
  assign m_char_o  = out_char_q;
  assign m_last_o  = out_last_q;

endmodule

// ----- sv/base64_encoder_line_wrap_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// base64_encoder_line_wrap_unit - streaming base64 encoder with line breaks
//
//   channel  dir  tdata            tlast       handshake
//   s_axis   in   data_byte [7:0]  last_byte   tvalid/tready
//   m_axis   out  out_char  [7:0]  last_char   tvalid/tready
//   cfg      in   line_length[9:0] -           cfg_we_i, no wait
//
// One output character leaves per cycle from the output register, unless the
// output stalls; a byte takes one to four characters plus two more per line
// break, paced by the emitter sequencer. A byte's first character passes the
// grouping set register, the emitter set register and the output register.
// Reset clears group state, line count and line length (72); no clearing pass.
// A stalled output holds its word while the grouping stage keeps one set.
// ============================================================================
module base64_encoder_line_wrap_unit #(
  parameter int unsigned LINE_COUNT_BITS = b64lw_pkg::LINE_COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration
  input  logic                        cfg_we_i,
  input  logic [b64lw_pkg::LEN_W-1:0] cfg_wdata_i,   // [9:0] line_length
  // Source bytes
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] data_byte
  input  logic                        s_axis_tlast_i,  // last_byte
  // Encoded characters
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,  // [7:0] out_char
  output logic                        m_axis_tlast_o   // last_char
);
  import b64lw_pkg::*;

  logic [LEN_W-1:0] line_length_q;
  logic             set_valid;
  logic             set_ready;
  set_t             set_w;

  // Line length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      line_length_q <= cfg_wdata_i;
    end
  end

  b64lw_group u_group (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_byte_i    (s_axis_tdata_i),
    .s_last_i    (s_axis_tlast_i),
    .set_valid_o (set_valid),
    .set_ready_i (set_ready),
    .set_o       (set_w)
  );

  b64lw_emit #(
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_length_i (line_length_q),
    .set_valid_i   (set_valid),
    .set_ready_o   (set_ready),
    .set_i         (set_w),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_char_o      (m_axis_tdata_o),
    .m_last_o      (m_axis_tlast_o)
  );

`ifndef ASSERT_OFF
  // A carriage return never closes the characters of a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o == CHAR_CR)) |-> !m_axis_tlast_o)
    else $error("CR word marked as last");

  // A taken carriage return is followed at once by a line feed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && (m_axis_tdata_o == CHAR_CR)) |=>
    (m_axis_tvalid_o && (m_axis_tdata_o == CHAR_LF)))
    else $error("CR not followed by LF");

  // Input stalls only while a set waits for the emitter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (set_valid && !set_ready))
    else $error("input stalled without a pending set");
`endif

endmodule

// ----- tb/base64_encoder_line_wrap_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// base64_encoder_line_wrap_unit_tb - self-checking bench for the base64 encoder
// Sends source bytes grouped into messages over the slave stream and stalls
// the character stream at random. Every character is predicted, including
// CR LF line breaks and '=' pads, and each character word is compared with
// the oldest prediction. Several line lengths are used, the extremes among
// them.
// ============================================================================
module base64_encoder_line_wrap_unit_tb;
  import b64lw_pkg::*;

  localparam int unsigned CNT_W          = LINE_COUNT_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned LONG_HOLD      = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i;
  logic             s_axis_tlast_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [7:0]       m_axis_tdata_o;
  logic             m_axis_tlast_o;

  // Encoder state as predicted by the bench
  logic [LEN_W-1:0] pred_len;
  phase_e           pred_phase;
  logic [3:0]       pred_carry;
  logic [CNT_W-1:0] pred_cnt;
  char_word_t       expected_chars[$];

  string       enc_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;
  bit          src_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned sink_hold = 0;

  base64_encoder_line_wrap_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Character prediction
  // ---------------------------------------------------------------------------
  function automatic void push_char(input logic [7:0] c);
    char_word_t w;
    w.ch   = c;
    w.last = 1'b0;
    expected_chars.push_back(w);
  endfunction

  // Counted character: append CR LF once the line is full
  function automatic void push_counted(input logic [7:0] c);
    push_char(c);
    if (pred_len != '0) begin
      pred_cnt = pred_cnt + 1'b1;
      if (pred_cnt == pred_len) begin
        pred_cnt = '0;
        push_char(CHAR_CR);
        push_char(CHAR_LF);
      end
    end
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return enc_alphabet[v];
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    char_word_t w;
    case (pred_phase)
      PH_SECOND: begin
        push_counted(sextet_char({pred_carry[1:0], b[7:4]}));
        pred_carry = b[3:0];
        pred_phase = PH_THIRD;
        if (fin) begin
          push_counted(sextet_char({pred_carry, 2'b00}));
          push_char(CHAR_PAD);
        end
      end
      PH_THIRD: begin
        push_counted(sextet_char({pred_carry, b[7:6]}));
        push_counted(sextet_char(b[5:0]));
        pred_carry = '0;
        pred_phase = PH_FIRST;
      end
      default: begin
        push_counted(sextet_char(b[7:2]));
        pred_carry = {2'b00, b[1:0]};
        pred_phase = PH_SECOND;
        if (fin) begin
          push_counted(sextet_char({pred_carry[1:0], 4'b0000}));
          push_counted(CHAR_PAD);
          push_char(CHAR_PAD);
        end
      end
    endcase
    // End of message: start the next one from a clean group and line
    if (fin) begin
      pred_phase = PH_FIRST;
      pred_carry = '0;
      pred_cnt   = '0;
    end
    w = expected_chars[expected_chars.size() - 1];
    w.last = 1'b1;
    expected_chars[expected_chars.size() - 1] = w;
  endfunction

  // Predict on accepted bytes, track register writes, check character words
  always @(posedge clk_i or negedge rst_ni) begin : char_checker
    char_word_t want;
    if (!rst_ni) begin
      pred_len   = LEN_RESET;
      pred_phase = PH_FIRST;
      pred_carry = '0;
      pred_cnt   = '0;
      expected_chars.delete();
    end else begin
      if (cfg_we_i) pred_len = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_o) encode_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected char word %02h last=%0b", m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata_o !== want.ch || m_axis_tlast_o !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("char word mismatch: expected %02h last=%0b, got %02h last=%0b",
                       want.ch, want.last, m_axis_tdata_o, m_axis_tlast_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Character sink: random stalls, or a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : char_sink
    int unsigned r;
    int unsigned n;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      n = 0;
      if (sink_hold != 0) begin
        n = sink_hold;
        sink_hold = 0;
        m_axis_tready_i <= 1'b0;
      end else if (!sink_stalls) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          m_axis_tready_i <= 1'b0;
          n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
      end
      if (n > 1) repeat (n - 1) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned r;
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r   = $urandom_range(0, 99);
    gap = 0;
    if (src_gaps) begin
      if (r >= 90)      gap = $urandom_range(6, 30);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    // Drop valid and scramble the idle word during a gap
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom_range(0, 255));
      s_axis_tlast_i  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Hold the source until every predicted character has left the block
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_line_length(input logic [LEN_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset line length; one, two and three byte messages
  task automatic test_default_length();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drained();
  endtask

  // Break after every counted character; the final pad is never counted
  task automatic test_narrow_lines();
    write_line_length(10'd1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    wait_drained();
  endtask

  // Full final group that fills the line ends with CR LF
  task automatic test_full_group_break();
    write_line_length(10'd4);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    wait_drained();
  endtask

  task automatic test_wrap_off();
    write_line_length(10'd0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_drained();
  endtask

  // Long sink hold-off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    write_line_length(10'd5);
    src_gaps  = 1'b0;
    sink_hold = LONG_HOLD;
    send_message(7);
    send_message(10);
    send_message(2);
    send_message(11);
    wait_drained();
    src_gaps = 1'b1;
  endtask

  task automatic test_random_messages();
    logic [LEN_W-1:0] len;
    int unsigned      sent;
    int unsigned      n;
    for (int k = 0; k < 8; k++) begin
      case (k)
        0:       len = 10'd0;
        1:       len = 10'd1023;
        2:       len = 10'd1;
        3:       len = 10'd2;
        4:       len = 10'd3;
        5:       len = LEN_W'($urandom_range(4, 100));
        6:       len = 10'd76;
        default: len = LEN_W'($urandom_range(0, 1023));
      endcase
      write_line_length(len);
      // One stretch with no idling on either side
      src_gaps    = (k != 3);
      sink_stalls = (k != 3);
      sent = 0;
      while (sent < 6) begin
        n = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 6) : $urandom_range(7, 20);
        send_message(n);
        sent += n;
      end
      wait_drained();
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_length();
    test_narrow_lines();
    test_full_group_break();
    test_wrap_off();
    test_backpressure();
    test_random_messages();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
